// ===== hw/rtl/rotint_pkg.sv =====
package rotint_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_BITS_DEF    = 18;

    localparam int ATAN_LEN    = 24;
    localparam int ROOT_BITS   = 31;  // integer square root of a value below 2^61
    localparam int QUO_BITS    = 15;  // quotient never exceeds 16384
    localparam int SHIFT_STEPS = 5;   // normalising shift of up to 31 places
    localparam int AXW         = 47;  // magnitude of a rotated component
    localparam int NORM_BITS   = 30;  // components after normalisation

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic        byp;
        logic [15:0] cos;
        logic [15:0] sin;
    } side_t;

    typedef struct packed {
        logic signed [15:0] cos;
        logic signed [15:0] sin;
    } pair_t;

    // table entry rounded half up to the chosen angle resolution
    function automatic logic [63:0] atan_entry(input int idx, input int angle_bits);
        logic [63:0] t;
        int          sh;
        t  = {32'd0, ATAN_TURN32[idx]};
        sh = 32 - angle_bits;
        if (sh == 0) begin
            return t;
        end
        return (t + (64'd1 << (sh - 1))) >> sh;
    endfunction

endpackage

// ===== hw/rtl/rotation_interpolate.sv =====
// Rotation interpolation between two unit vectors.
// Slave channel: one transfer carries first_cos, first_sin, second_cos, second_sin
// (all signed Q1.14) and fraction (signed Q1.14). Master channel: one transfer
// carries out_cos and out_sin (signed Q1.14) per input transfer, in order.
// A fraction at or below zero returns the first pair, at or above one the second.
// Otherwise the angle of conj(first)*second is found by a vectoring CORDIC,
// scaled by the fraction, turned into a cosine/sine pair by a rotation CORDIC,
// applied to the first pair, and the product is normalised to unit length by
// a bit-per-stage square root and two bit-per-stage dividers.
// Throughput: one transfer per cycle in each direction while the receiver accepts;
// every stage is a register and the whole pipeline advances together.
// The pipeline depth is set by the two CORDICs (one stage per iteration),
// the 31-stage square root and the 15-stage dividers.
// Reset clears all valid bits; the pipeline is then empty and s_tready high.
// When the receiver stalls with a result waiting, the whole pipeline holds,
// s_tready falls with it, and nothing is lost or repeated.
module rotation_interpolate #(
    parameter int CORDIC_STAGES = rotint_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_BITS    = rotint_pkg::ANGLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_cos, first_sin, second_cos, second_sin, fraction
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_cos, out_sin
    output logic [31:0] m_tdata
);
    import rotint_pkg::*;

    localparam int N   = CORDIC_STAGES;
    localparam int AW  = ANGLE_BITS + 2;
    localparam int XW  = 35;
    localparam int RW  = 31;
    localparam int PW  = 47;
    localparam int RXW = 48;
    localparam int QN  = ROOT_BITS;
    localparam int DN  = QUO_BITS;
    localparam int DW  = 46;

    localparam int IX_V0  = 3;
    localparam int IX_SC1 = 4 + N;
    localparam int IX_R0  = 6 + N;
    localparam int IX_M1  = 8 + 2 * N;
    localparam int IX_T   = 10 + 2 * N;
    localparam int IX_D0  = 49 + 2 * N;
    localparam int IX_OUT = 65 + 2 * N;
    localparam int DEPTH  = 66 + 2 * N;
    localparam int SGN    = IX_OUT - IX_T;

    localparam logic signed [AW-1:0]   QUARTER = AW'(64'd1 << (ANGLE_BITS - 2));
    localparam logic signed [AW-1:0]   HALF    = AW'(64'd1 << (ANGLE_BITS - 1));
    localparam logic signed [AW+15:0]  RND     = (AW + 16)'(8192);
    localparam logic signed [32:0]     LIM_P   = 33'sd16384;
    localparam logic signed [RXW-1:0]  LIM_R   = RXW'(64'd1 << 28);
    localparam logic signed [RW-1:0]   X_START = RW'(64'd1 << 28);

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // valid bits and early-result line
    logic  v_reg   [DEPTH];
    side_t sd_reg  [DEPTH];
    side_t sd_next [DEPTH];

    logic signed [15:0] in_f;
    logic               tiny_r;
    assign in_f = $signed(s_tdata[79:64]);

    // payload shift lines
    pair_t              p1_reg [IX_M1];
    logic signed [15:0] f_reg  [IX_SC1];
    logic signed [15:0] c2_reg, s2_reg;

    logic signed [31:0] mcc_reg, mss_reg, mcs_reg, msc_reg;
    logic signed [32:0] px_reg, py_reg;

    logic               zr_reg [N+1];
    logic signed [XW-1:0] vx_reg [N+1];
    logic signed [XW-1:0] vy_reg [N+1];
    logic signed [AW-1:0] vz_reg [N+1];

    logic signed [AW+15:0] sp_reg;
    logic signed [AW-1:0]  sa_reg;

    logic                 rfl_reg [N+1];
    logic signed [RW-1:0] rxc_reg [N+1];
    logic signed [RW-1:0] ryc_reg [N+1];
    logic signed [AW-1:0] ra_reg  [N+1];

    logic signed [RW-1:0]  cr_reg, sr_reg;
    logic signed [PW-1:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [RXW-1:0] rx_reg, ry_reg;

    logic [1:0]     sg_reg  [SGN];
    logic [AXW-1:0] shx_reg [SHIFT_STEPS+1];
    logic [AXW-1:0] shy_reg [SHIFT_STEPS+1];

    logic [NORM_BITS-1:0]   s1x_reg, s1y_reg;
    logic [2*NORM_BITS-1:0] sqa_reg, sqb_reg;

    logic [60:0]          qv_reg [QN+1];
    logic [ROOT_BITS-1:0] qr_reg [QN+1];
    logic [NORM_BITS-1:0] qx_reg [QN+1];
    logic [NORM_BITS-1:0] qy_reg [QN+1];

    logic [DW-1:0]       drx_reg [DN+1];
    logic [DW-1:0]       dry_reg [DN+1];
    logic [31:0]         dd_reg  [DN+1];
    logic [QUO_BITS-1:0] dqx_reg [DN+1];
    logic [QUO_BITS-1:0] dqy_reg [DN+1];

    logic [31:0] out_reg;

    // ---------------------------------------------------------------- control line
    always_comb begin
        if (in_f <= 16'sd0) begin
            sd_next[0] = '{byp: 1'b1, cos: s_tdata[15:0], sin: s_tdata[31:16]};
        end else if (in_f >= ONE_Q14) begin
            sd_next[0] = '{byp: 1'b1, cos: s_tdata[47:32], sin: s_tdata[63:48]};
        end else begin
            sd_next[0] = '{byp: 1'b0, cos: 16'd0, sin: 16'd0};
        end
        for (int k = 1; k < DEPTH; k++) begin
            sd_next[k] = sd_reg[k-1];
        end
        // vanishing rotated vector or zero magnitude: answer is (1, 0)
        if (!sd_reg[IX_T-1].byp && tiny_r) begin
            sd_next[IX_T] = '{byp: 1'b1, cos: ONE_Q14, sin: 16'd0};
        end
        if (!sd_reg[IX_D0-1].byp && (qr_reg[QN] == '0)) begin
            sd_next[IX_D0] = '{byp: 1'b1, cos: ONE_Q14, sin: 16'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k < DEPTH; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DEPTH; k++) begin
                sd_reg[k] <= sd_next[k];
            end
        end
    end

    // ---------------------------------------------------------------- input and product
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg[0] <= '{cos: $signed(s_tdata[15:0]), sin: $signed(s_tdata[31:16])};
            c2_reg    <= $signed(s_tdata[47:32]);
            s2_reg    <= $signed(s_tdata[63:48]);
            f_reg[0]  <= in_f;
            for (int k = 1; k < IX_M1; k++) begin
                p1_reg[k] <= p1_reg[k-1];
            end
            for (int k = 1; k < IX_SC1; k++) begin
                f_reg[k] <= f_reg[k-1];
            end
            mcc_reg <= 32'(p1_reg[0].cos) * 32'(c2_reg);
            mss_reg <= 32'(p1_reg[0].sin) * 32'(s2_reg);
            mcs_reg <= 32'(p1_reg[0].cos) * 32'(s2_reg);
            msc_reg <= 32'(p1_reg[0].sin) * 32'(c2_reg);
            px_reg  <= 33'(mcc_reg) + 33'(mss_reg);
            py_reg  <= 33'(mcs_reg) - 33'(msc_reg);
        end
    end

    // ---------------------------------------------------------------- vectoring CORDIC
    logic               p_in;
    logic signed [14:0] tpx, tpy;
    logic signed [29:0] psx, psy;
    logic               p_tiny;
    logic signed [XW-1:0] v0x, v0y, pxe, pye;
    logic signed [AW-1:0] v0z;

    always_comb begin
        p_in   = (px_reg > -LIM_P) && (px_reg < LIM_P) && (py_reg > -LIM_P) && (py_reg < LIM_P);
        tpx    = px_reg[14:0];
        tpy    = py_reg[14:0];
        psx    = 30'(tpx) * 30'(tpx);
        psy    = 30'(tpy) * 30'(tpy);
        p_tiny = p_in && ((31'(psx) + 31'(psy)) < 31'sd268435456);
        pxe    = XW'(px_reg);
        pye    = XW'(py_reg);
        v0x    = pxe;
        v0y    = pye;
        v0z    = '0;
        // fold the left half-plane onto the right
        if (pxe < 0) begin
            if (pye >= 0) begin
                v0x = pye;
                v0y = -pxe;
                v0z = QUARTER;
            end else begin
                v0x = -pye;
                v0y = pxe;
                v0z = -QUARTER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zr_reg[0] <= p_tiny;
            vx_reg[0] <= v0x;
            vy_reg[0] <= v0y;
            vz_reg[0] <= v0z;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec
        localparam logic signed [AW-1:0] AT = AW'(atan_entry(i, ANGLE_BITS));
        logic signed [XW-1:0] dx, dy;
        assign dx = vy_reg[i] >>> i;
        assign dy = vx_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (adv) begin
                zr_reg[i+1] <= zr_reg[i];
                if (!vy_reg[i][XW-1]) begin
                    vx_reg[i+1] <= vx_reg[i] + dx;
                    vy_reg[i+1] <= vy_reg[i] - dy;
                    vz_reg[i+1] <= vz_reg[i] + AT;
                end else begin
                    vx_reg[i+1] <= vx_reg[i] - dx;
                    vy_reg[i+1] <= vy_reg[i] + dy;
                    vz_reg[i+1] <= vz_reg[i] - AT;
                end
            end
        end
    end

    // ---------------------------------------------------------------- angle scaling
    logic signed [AW-1:0]  ang;
    logic signed [AW+15:0] sp_rnd;
    logic signed [AW-1:0]  fold_a;
    logic                  fold_f;

    always_comb begin
        ang    = zr_reg[N] ? '0 : vz_reg[N];
        sp_rnd = sp_reg + RND;
        fold_a = sa_reg;
        fold_f = 1'b0;
        if (sa_reg > QUARTER) begin
            fold_a = sa_reg - HALF;
            fold_f = 1'b1;
        end else if (sa_reg < -QUARTER) begin
            fold_a = sa_reg + HALF;
            fold_f = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sp_reg     <= (AW + 16)'(ang) * (AW + 16)'(f_reg[IX_SC1-1]);
            sa_reg     <= sp_rnd[AW+13:14];
            ra_reg[0]  <= fold_a;
            rfl_reg[0] <= fold_f;
            rxc_reg[0] <= X_START;
            ryc_reg[0] <= '0;
        end
    end

    // ---------------------------------------------------------------- rotation CORDIC
    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [AW-1:0] AT = AW'(atan_entry(i, ANGLE_BITS));
        logic signed [RW-1:0] dx, dy;
        assign dx = ryc_reg[i] >>> i;
        assign dy = rxc_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (adv) begin
                rfl_reg[i+1] <= rfl_reg[i];
                if (!ra_reg[i][AW-1]) begin
                    rxc_reg[i+1] <= rxc_reg[i] - dx;
                    ryc_reg[i+1] <= ryc_reg[i] + dy;
                    ra_reg[i+1]  <= ra_reg[i] - AT;
                end else begin
                    rxc_reg[i+1] <= rxc_reg[i] + dx;
                    ryc_reg[i+1] <= ryc_reg[i] - dy;
                    ra_reg[i+1]  <= ra_reg[i] + AT;
                end
            end
        end
    end

    // ---------------------------------------------------------------- apply to first pair
    logic signed [RXW-1:0] tax_full, tay_full;
    logic signed [28:0]    trx, try_v;
    logic signed [57:0]    rsx, rsy;

    always_comb begin
        trx      = rx_reg[28:0];
        try_v    = ry_reg[28:0];
        rsx      = 58'(trx) * 58'(trx);
        rsy      = 58'(try_v) * 58'(try_v);
        tiny_r   = (rx_reg > -LIM_R) && (rx_reg < LIM_R) && (ry_reg > -LIM_R) && (ry_reg < LIM_R)
                   && ((59'(rsx) + 59'(rsy)) < (59'sd1 <<< 56));
        tax_full = rx_reg[RXW-1] ? -rx_reg : rx_reg;
        tay_full = ry_reg[RXW-1] ? -ry_reg : ry_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cr_reg     <= rfl_reg[N] ? -rxc_reg[N] : rxc_reg[N];
            sr_reg     <= rfl_reg[N] ? -ryc_reg[N] : ryc_reg[N];
            pa_reg     <= PW'(p1_reg[IX_M1-1].cos) * PW'(cr_reg);
            pb_reg     <= PW'(p1_reg[IX_M1-1].sin) * PW'(sr_reg);
            pc_reg     <= PW'(p1_reg[IX_M1-1].cos) * PW'(sr_reg);
            pd_reg     <= PW'(p1_reg[IX_M1-1].sin) * PW'(cr_reg);
            rx_reg     <= RXW'(pa_reg) - RXW'(pb_reg);
            ry_reg     <= RXW'(pc_reg) + RXW'(pd_reg);
            shx_reg[0] <= tax_full[AXW-1:0];
            shy_reg[0] <= tay_full[AXW-1:0];
            sg_reg[0]  <= {ry_reg[RXW-1], rx_reg[RXW-1]};
            for (int k = 1; k < SGN; k++) begin
                sg_reg[k] <= sg_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- normalising shift
    for (genvar j = 0; j < SHIFT_STEPS; j++) begin : g_shift
        localparam int SHA = (1 << (SHIFT_STEPS - 1)) >> j;
        logic [AXW-1:0] both;
        logic           big;
        assign both = shx_reg[j] | shy_reg[j];
        assign big  = |both[AXW-1:NORM_BITS-1+SHA];
        always_ff @(posedge aclk) begin
            if (adv) begin
                shx_reg[j+1] <= big ? (shx_reg[j] >> SHA) : shx_reg[j];
                shy_reg[j+1] <= big ? (shy_reg[j] >> SHA) : shy_reg[j];
            end
        end
    end

    // ---------------------------------------------------------------- magnitude
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1x_reg   <= shx_reg[SHIFT_STEPS][NORM_BITS-1:0];
            s1y_reg   <= shy_reg[SHIFT_STEPS][NORM_BITS-1:0];
            sqa_reg   <= (2 * NORM_BITS)'(shx_reg[SHIFT_STEPS][NORM_BITS-1:0])
                         * (2 * NORM_BITS)'(shx_reg[SHIFT_STEPS][NORM_BITS-1:0]);
            sqb_reg   <= (2 * NORM_BITS)'(shy_reg[SHIFT_STEPS][NORM_BITS-1:0])
                         * (2 * NORM_BITS)'(shy_reg[SHIFT_STEPS][NORM_BITS-1:0]);
            qv_reg[0] <= 61'(sqa_reg) + 61'(sqb_reg);
            qr_reg[0] <= '0;
            qx_reg[0] <= s1x_reg;
            qy_reg[0] <= s1y_reg;
        end
    end

    // one root bit per stage, most significant first
    for (genvar j = 0; j < QN; j++) begin : g_sqrt
        localparam int BIT = QN - 1 - j;
        logic [62:0] trial;
        logic        take;
        assign trial = (63'(qr_reg[j]) << (BIT + 1)) + (63'd1 << (2 * BIT));
        assign take  = 63'(qv_reg[j]) >= trial;
        always_ff @(posedge aclk) begin
            if (adv) begin
                qv_reg[j+1] <= take ? (qv_reg[j] - trial[60:0]) : qv_reg[j];
                qr_reg[j+1] <= take ? (qr_reg[j] | (ROOT_BITS'(1) << BIT)) : qr_reg[j];
                qx_reg[j+1] <= qx_reg[j];
                qy_reg[j+1] <= qy_reg[j];
            end
        end
    end

    // ---------------------------------------------------------------- rounded division
    always_ff @(posedge aclk) begin
        if (adv) begin
            drx_reg[0] <= (DW'(qx_reg[QN]) << 15) + DW'(qr_reg[QN]);
            dry_reg[0] <= (DW'(qy_reg[QN]) << 15) + DW'(qr_reg[QN]);
            dd_reg[0]  <= {qr_reg[QN], 1'b0};
            dqx_reg[0] <= '0;
            dqy_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < DN; j++) begin : g_div
        localparam int K = DN - 1 - j;
        logic [DW-1:0] dk;
        logic          tx, ty;
        assign dk = DW'(dd_reg[j]) << K;
        assign tx = drx_reg[j] >= dk;
        assign ty = dry_reg[j] >= dk;
        always_ff @(posedge aclk) begin
            if (adv) begin
                drx_reg[j+1] <= tx ? (drx_reg[j] - dk) : drx_reg[j];
                dry_reg[j+1] <= ty ? (dry_reg[j] - dk) : dry_reg[j];
                dqx_reg[j+1] <= {dqx_reg[j][QUO_BITS-2:0], tx};
                dqy_reg[j+1] <= {dqy_reg[j][QUO_BITS-2:0], ty};
                dd_reg[j+1]  <= dd_reg[j];
            end
        end
    end

    // ---------------------------------------------------------------- output register
    logic [15:0] qc, qs;
    logic [15:0] oc, os;

    always_comb begin
        qc = {1'b0, dqx_reg[DN]};
        qs = {1'b0, dqy_reg[DN]};
        oc = sg_reg[SGN-1][0] ? (16'd0 - qc) : qc;
        os = sg_reg[SGN-1][1] ? (16'd0 - qs) : qs;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (sd_reg[IX_OUT-1].byp) begin
                out_reg <= {sd_reg[IX_OUT-1].sin, sd_reg[IX_OUT-1].cos};
            end else begin
                out_reg <= {os, oc};
            end
        end
    end

    assign m_tvalid = v_reg[IX_OUT];
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_vec_right_half: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[IX_V0] && !zr_reg[0] |-> !vx_reg[0][XW-1])
        else $error("vectoring start left of the axis");

    a_rot_folded: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[IX_R0] && !sd_reg[IX_R0].byp
        |-> (ra_reg[0] <= QUARTER) && (ra_reg[0] >= -QUARTER))
        else $error("rotation angle outside a quarter turn after fold");

    a_root_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[IX_D0-1] && !sd_reg[IX_D0-1].byp
        |-> qr_reg[QN] != '0)
        else $error("zero magnitude passed the small-vector check");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[IX_OUT-1] && !sd_reg[IX_OUT-1].byp
        |-> (drx_reg[DN] < DW'(dd_reg[DN])) && (dry_reg[DN] < DW'(dd_reg[DN])))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== tb/sv/tb_rotation_interpolate.sv =====
`timescale 1ns / 1ps

module tb_rotation_interpolate;

    localparam int STAGES   = rotint_pkg::CORDIC_STAGES_DEF;
    localparam int ABITS    = rotint_pkg::ANGLE_BITS_DEF;
    localparam int TBL_SH   = 32 - ABITS;
    localparam int HOLD_LEN = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // first_cos, first_sin, second_cos, second_sin, fraction
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // out_cos, out_sin
    logic [31:0] m_tdata;

    logic [79:0] pending_q [$];
    logic [31:0] rotation_q [$];
    int          idle_pct;
    int          stall_pct;
    int          errors;
    logic        took_last;
    logic        hold_go;
    logic        hold_seen;
    int          hold_cnt;

    rotation_interpolate u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    function automatic longint atan_step(int i);
        longint t;
        t = longint'(rotint_pkg::ATAN_TURN32[i]);
        if (TBL_SH == 0) begin
            return t;
        end
        return (t + (64'sd1 <<< (TBL_SH - 1))) >>> TBL_SH;
    endfunction

    function automatic bit under_lsb(longint x, longint y, int lsb);
        longint lim;
        lim = 64'sd1 <<< lsb;
        if (x <= -lim || x >= lim || y <= -lim || y >= lim) begin
            return 1'b0;
        end
        return (x * x + y * y) < (64'sd1 <<< (2 * lsb));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint phase_of(longint x, longint y);
        longint quarter, z, t, dx, dy;
        quarter = 64'sd1 <<< (ABITS - 2);
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = quarter;
            end else begin
                t = x; x = -y; y = t; z = -quarter;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + atan_step(i);
            end else begin
                x = x - dx; y = y + dy; z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    // interpolated rotation for one transfer, packed as on m_tdata
    function automatic logic [31:0] blend_rotation(logic [79:0] d);
        longint c1, s1, c2, s2, f, px, py, a, x, y, dx, dy, rx, ry, quarter, half;
        longint unsigned ax, ay, mag, qx, qy;
        bit flip, nx, ny;
        logic [15:0] oc, os;
        c1 = longint'($signed(d[15:0]));
        s1 = longint'($signed(d[31:16]));
        c2 = longint'($signed(d[47:32]));
        s2 = longint'($signed(d[63:48]));
        f  = longint'($signed(d[79:64]));
        if (f <= 0) begin
            return d[31:0];
        end
        if (f >= 16384) begin
            return d[63:32];
        end
        px = c1 * c2 + s1 * s2;
        py = c1 * s2 - s1 * c2;
        a = under_lsb(px, py, 14) ? 0 : phase_of(px, py);
        a = (a * f + 8192) >>> 14;
        quarter = 64'sd1 <<< (ABITS - 2);
        half = 64'sd1 <<< (ABITS - 1);
        flip = 1'b0;
        if (a > quarter) begin
            a = a - half; flip = 1'b1;
        end else if (a < -quarter) begin
            a = a + half; flip = 1'b1;
        end
        x = 64'sd1 <<< 28;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                x = x - dx; y = y + dy; a = a - atan_step(i);
            end else begin
                x = x + dx; y = y - dy; a = a + atan_step(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        rx = c1 * x - s1 * y;
        ry = c1 * y + s1 * x;
        if (under_lsb(rx, ry, 28)) begin
            return {16'd0, 16'd16384};
        end
        nx = rx < 0;
        ny = ry < 0;
        ax = nx ? -rx : rx;
        ay = ny ? -ry : ry;
        while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        mag = int_sqrt(ax * ax + ay * ay);
        if (mag == 0) begin
            return {16'd0, 16'd16384};
        end
        qx = (2 * ax * 16384 + mag) / (2 * mag);
        qy = (2 * ay * 16384 + mag) / (2 * mag);
        oc = nx ? -qx[15:0] : qx[15:0];
        os = ny ? -qy[15:0] : qy[15:0];
        return {os, oc};
    endfunction

    task automatic queue_item(int c1, int s1, int c2, int s2, int f);
        logic [15:0] a, b, c, e, g;
        a = 16'(c1); b = 16'(s1); c = 16'(c2); e = 16'(s2); g = 16'(f);
        pending_q.push_back({g, e, c, b, a});
    endtask

    function automatic int q14_any();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    task automatic queue_random(int n);
        int f, kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            f = int'($urandom_range(1, 16383));
            if (kind == 0) begin
                // raw noise on every bit
                pending_q.push_back({$urandom(), $urandom(), 16'($urandom())});
            end else if (kind == 1) begin
                f = $urandom_range(0, 1) ? -int'($urandom_range(0, 32768))
                                          : int'($urandom_range(16384, 32767));
                queue_item(q14_any(), q14_any(), q14_any(), q14_any(), f);
            end else begin
                queue_item(q14_any(), q14_any(), q14_any(), q14_any(), f);
            end
        end
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || rotation_q.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb_rotation_interpolate failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_seen <= 1'b0;
            hold_cnt  <= 0;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt  <= HOLD_LEN;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // driver: keep offering until the transfer has happened
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || took_last) begin
                if (pending_q.size() != 0 && int'($urandom_range(0, 99)) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= (hold_cnt == 0) && (int'($urandom_range(0, 99)) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        took_last <= s_tvalid && s_tready && aresetn;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rotation_q.push_back(blend_rotation(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (rotation_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = rotation_q.pop_front();
                    if (want[15:0] !== m_tdata[15:0]) begin
                        $display("%0t: out_cos expected %0d actual %0d", $time,
                                 $signed(want[15:0]), $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (want[31:16] !== m_tdata[31:16]) begin
                        $display("%0t: out_sin expected %0d actual %0d", $time,
                                 $signed(want[31:16]), $signed(m_tdata[31:16]));
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int waited;
        errors    = 0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        took_last = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ends of the fraction range and bypass paths
        queue_item(16384, 0, 0, 16384, 0);
        queue_item(-16384, 0, 0, -16384, -32768);
        queue_item(11585, 11585, 0, 16384, -1);
        queue_item(16384, 0, 0, 16384, 16384);
        queue_item(0, 16384, -16384, 0, 32767);
        queue_item(16384, 0, 0, 16384, 8192);
        queue_item(16384, 0, 0, 16384, 1);
        queue_item(16384, 0, 0, 16384, 16383);
        queue_item(16384, 0, 0, -16384, 8192);
        queue_item(16384, 0, -16384, 0, 8192);
        queue_item(16384, 0, -16384, 1, 8192);
        queue_item(16384, 0, -16384, -1, 8192);
        queue_item(0, -16384, 0, 16384, 4096);
        // zero product gives angle zero
        queue_item(16384, 0, 0, 0, 8192);
        queue_item(0, 0, 0, 0, 8192);
        // zero first pair gives a vanishing result; a tiny one is still normalised
        queue_item(0, 0, 16384, 0, 5000);
        queue_item(1, 0, 0, 1, 12000);
        // inputs outside the unit circle
        queue_item(-32768, 32767, 32767, -32768, 8192);
        queue_item(32767, 32767, -32768, -32768, 16383);
        queue_item(-32768, -32768, -32768, -32768, 1);
        queue_item(-1, -1, -1, -1, 16383);
        drain();

        queue_random(70);
        drain();

        idle_pct = 82; stall_pct = 0;
        queue_random(70);
        drain();

        idle_pct = 0; stall_pct = 82;
        queue_random(70);
        drain();

        // long receiver hold-off while the sender runs flat out, past the pipeline depth
        idle_pct = 0; stall_pct = 0;
        queue_random(130);
        hold_go = 1'b1;
        drain();

        idle_pct = 12; stall_pct = 12;
        queue_random(70);
        drain();

        waited = 0;
        while (waited < 300) begin
            @(posedge aclk);
            waited++;
        end
        if (errors == 0 && rotation_q.size() == 0) begin
            $display("tb_rotation_interpolate passed");
        end else begin
            $display("tb_rotation_interpolate failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rotint_pkg.sv
hw/rtl/rotation_interpolate.sv
tb/sv/tb_rotation_interpolate.sv
